/* rtl/core/packet_classifier_trie_step_top_assert.svh */
// Assertion macros for the trie step block.
`ifndef PACKET_CLASSIFIER_TRIE_STEP_TOP_ASSERT_SVH
`define PACKET_CLASSIFIER_TRIE_STEP_TOP_ASSERT_SVH

`ifndef SYNTH
`define PCT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pct assertion failed");
`define PCT_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pct forbidden condition seen");
`else
`define PCT_ASSERT(label, clk, rst, prop)
`define PCT_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* rtl/core/pct_pkg.sv */
package pct_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned SLOT_W  = 3;
   localparam int unsigned TADDR_W = 12;
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned REG_W   = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [REG_W-1:0] INDEX_MASK_RST = 32'h3FFF_FFFF;
   localparam logic [REG_W-1:0] RANGE_TYPE_RST = 32'h4000_0000;
   localparam logic [REG_W-1:0] MATCH_MASK_RST = 32'h8000_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_BYTE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INDEX_MASK = 2'd0,
      CSR_RANGE_TYPE = 2'd1,
      CSR_MATCH_MASK = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLOT,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [SLOT_W-1:0]  slot;
      logic [TADDR_W-1:0] table_addr;
      logic [WORD_W-1:0]  word;
      logic [BYTE_W-1:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic              matched;
      logic [REG_W-1:0]  node_index;
      logic              out_of_range;
      logic [WORD_W-1:0] current_word;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic walk;
      logic commit;
   } ctl_cmd_type;

endpackage

/* rtl/core/pct_ctrl.sv */
module pct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output pct_pkg::ctl_cmd_type ctl_cmd
);

   pct_pkg::state_type state_ff;
   pct_pkg::state_type state_in;
   logic               strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pct_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= ctl_cmd.commit;
      end
   end

   always_comb begin
      state_in        = state_ff;
      ctl_cmd.capture = 1'b0;
      ctl_cmd.walk    = 1'b0;
      ctl_cmd.commit  = 1'b0;
      busy            = 1'b1;
      case (state_ff)
         pct_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl_cmd.capture = 1'b1;
               state_in        = pct_pkg::ST_SLOT;
            end
         end
         pct_pkg::ST_SLOT: begin
            ctl_cmd.walk = 1'b1;
            state_in     = pct_pkg::ST_FETCH;
         end
         pct_pkg::ST_FETCH: begin
            ctl_cmd.commit = 1'b1;
            state_in       = pct_pkg::ST_IDLE;
         end
         default: begin
            state_in = pct_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;

endmodule

/* rtl/core/pct_dpath.sv */
module pct_dpath #(
   parameter int unsigned TABLE_ENTRIES = 4096,
   parameter int unsigned SLOTS         = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pct_pkg::ctl_cmd_type                 ctl_cmd,
   input  pct_pkg::req_item_type                req_item,
   input  logic                                 csr_wr,
   input  logic [pct_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pct_pkg::REG_W-1:0]            csr_data,
   output pct_pkg::rsp_item_type                rsp_item
);

   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned RW = pct_pkg::REG_W;
   localparam int unsigned WW = pct_pkg::WORD_W;

   logic [WW-1:0] table_mem [0:TABLE_ENTRIES-1];
   logic [WW-1:0] slot_mem  [0:SLOTS-1];

   logic [RW-1:0] index_mask_ff;
   logic [RW-1:0] range_type_ff;
   logic [RW-1:0] match_mask_ff;

   pct_pkg::req_item_type req_ff;
   logic [WW-1:0]  slot_rd_ff;
   logic [WW-1:0]  tbl_rd_ff;
   logic [WW-1:0]  cur_word_ff;
   logic           err_cur_ff;
   logic           step_ff;
   logic           err_set_ff;
   logic [SLOTS-1:0] slot_vld_ff;
   logic [SLOTS-1:0] slot_err_ff;
   pct_pkg::rsp_item_type rsp_ff;

   logic           load_ok;
   logic           is_start;
   logic           is_byte;
   logic           slot_ok;
   logic [SW-1:0]  slot_idx;
   logic           cur_vld;
   logic           cur_err;
   logic [WW-1:0]  cur_word;
   logic [RW-1:0]  lo;
   logic [RW-1:0]  node_type;
   logic [2:0]     range_cnt;
   logic [RW-1:0]  offset;
   logic [RW-1:0]  addr;
   logic           addr_ok;
   logic           active;
   logic           upd;
   logic [WW-1:0]  word_in;
   logic           err_in;
   pct_pkg::rsp_item_type rsp_in;

   assign load_ok = (req_item.cmd == pct_pkg::CMD_LOAD)
                  && (RW'(req_item.table_addr) < RW'(TABLE_ENTRIES));

   always_ff @(posedge clock) begin
      if (reset) begin
         index_mask_ff <= pct_pkg::INDEX_MASK_RST;
         range_type_ff <= pct_pkg::RANGE_TYPE_RST;
         match_mask_ff <= pct_pkg::MATCH_MASK_RST;
      end else if (csr_wr) begin
         case (csr_index)
            pct_pkg::CSR_INDEX_MASK: index_mask_ff <= csr_data;
            pct_pkg::CSR_RANGE_TYPE: range_type_ff <= csr_data;
            pct_pkg::CSR_MATCH_MASK: match_mask_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture && load_ok) begin
         table_mem[AW'(req_item.table_addr)] <= req_item.word;
      end
      if (ctl_cmd.walk) begin
         tbl_rd_ff <= table_mem[AW'(addr)];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         req_ff     <= req_item;
         slot_rd_ff <= slot_mem[SW'(req_item.slot)];
      end
      if (ctl_cmd.commit && upd) begin
         slot_mem[slot_idx] <= word_in;
      end
   end

   assign is_start = (req_ff.cmd == pct_pkg::CMD_START);
   assign is_byte  = (req_ff.cmd == pct_pkg::CMD_BYTE);
   assign slot_ok  = (RW'(req_ff.slot) < RW'(SLOTS));
   assign slot_idx = SW'(req_ff.slot);
   assign cur_vld  = slot_ok ? slot_vld_ff[slot_idx] : 1'b0;
   assign cur_err  = slot_ok ? slot_err_ff[slot_idx] : 1'b0;
   assign cur_word = cur_vld ? slot_rd_ff : '0;

   assign lo        = cur_word[RW-1:0];
   assign node_type = lo & ~index_mask_ff;

   always_comb begin
      range_cnt = 3'd0;
      for (int k = 0; k < 4; k++) begin
         if ($signed(req_ff.data_byte) > $signed(cur_word[RW + 8*k +: 8])) begin
            range_cnt = range_cnt + 3'd1;
         end
      end
   end

   always_comb begin
      offset = '0;
      if (node_type == '0) begin
         offset = RW'(req_ff.data_byte);
      end
      if (node_type == range_type_ff) begin
         offset = offset + RW'(range_cnt);
      end
   end

   assign addr    = (lo & index_mask_ff) + offset;
   assign addr_ok = (addr < RW'(TABLE_ENTRIES));
   assign active  = is_byte && slot_ok && !cur_err && ((lo & match_mask_ff) == '0);

   always_ff @(posedge clock) begin
      if (ctl_cmd.walk) begin
         cur_word_ff <= cur_word;
         err_cur_ff  <= cur_err;
         step_ff     <= active && addr_ok;
         err_set_ff  <= active && !addr_ok;
      end
   end

   assign upd = slot_ok && (is_start || is_byte);

   always_comb begin
      if (is_start) begin
         word_in = req_ff.word;
         err_in  = 1'b0;
      end else begin
         word_in = step_ff ? tbl_rd_ff : cur_word_ff;
         err_in  = err_cur_ff || err_set_ff;
      end
      rsp_in = '0;
      if (upd) begin
         rsp_in.matched      = ((word_in[RW-1:0] & match_mask_ff) != '0);
         rsp_in.node_index   = word_in[RW-1:0] & index_mask_ff;
         rsp_in.out_of_range = err_in;
         rsp_in.current_word = word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         slot_err_ff <= '0;
      end else if (ctl_cmd.commit && upd) begin
         slot_vld_ff[slot_idx] <= 1'b1;
         slot_err_ff[slot_idx] <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

/* rtl/core/packet_classifier_trie_step_top.sv */
// The result strobe is registered from the slot write-back of an accepted item.
// No new item is taken while busy. The slot is read at the accepting edge; busy
// covers the address add with its table fetch and the slot write-back.
// Reset: synchronous, active high; slots read as zero with errors clear, registers
// take their defaults, the transition table is undefined until loaded.
// The receiver cannot stall: rsp_strobe marks a result for one cycle.
module packet_classifier_trie_step_top #(
   parameter int unsigned TABLE_ENTRIES = 4096,
   parameter int unsigned SLOTS         = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pct_pkg::req_item_type         req_item,
   output logic                          rsp_strobe,
   output pct_pkg::rsp_item_type         rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pct_pkg::REG_W-1:0]     csr_data
);

   `include "packet_classifier_trie_step_top_assert.svh"

   pct_pkg::ctl_cmd_type ctl_cmd;
   logic                 csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   pct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl_cmd    (ctl_cmd)
   );

   pct_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .SLOTS         (SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl_cmd   (ctl_cmd),
      .req_item  (req_item),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item)
   );

   `PCT_ASSERT(a_accept_busy, clock, reset, start && !busy |=> busy)
   `PCT_ASSERT(a_accept_result, clock, reset, start && !busy |-> ##3 rsp_strobe)
   `PCT_ASSERT(a_single_strobe, clock, reset, rsp_strobe |=> !rsp_strobe)
   `PCT_ASSERT_NEVER(a_strobe_busy, clock, reset, rsp_strobe && busy)

endmodule

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pct_pkg::*;

   localparam int unsigned TABLE_ENTRIES = 4096;
   localparam int unsigned SLOTS         = 8;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_item_type         req_item;
   logic                 rsp_strobe;
   rsp_item_type         rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_data;

   bit [63:0]    trie_table [TABLE_ENTRIES];
   bit           trie_loaded [TABLE_ENTRIES];
   bit [63:0]    slot_words [SLOTS];
   bit           slot_fault [SLOTS];
   bit [31:0]    idx_mask_r   = INDEX_MASK_RST;
   bit [31:0]    rng_type_r   = RANGE_TYPE_RST;
   bit [31:0]    match_mask_r = MATCH_MASK_RST;
   rsp_item_type slot_report_q [$];
   rsp_item_type want;
   int unsigned  fail_count  = 0;
   int unsigned  cycle_count = 0;
   int unsigned  items_sent  = 0;
   bit           quiet_run   = 1'b0;

   packet_classifier_trie_step_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .SLOTS(SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] bound_count(logic [63:0] w, logic [7:0] b);
      logic [31:0] n;
      n = 0;
      for (int k = 0; k < 4; k++) begin
         if ($signed(b) > $signed(w[32 + 8*k +: 8])) n++;
      end
      return n;
   endfunction

   function automatic logic [31:0] walk_addr(logic [63:0] w, logic [7:0] b);
      logic [31:0] lo;
      logic [31:0] typ;
      logic [31:0] addr;
      lo   = w[31:0];
      typ  = lo & ~idx_mask_r;
      addr = lo & idx_mask_r;
      if (typ == 32'd0) addr = addr + {24'd0, b};
      if (typ == rng_type_r) addr = addr + bound_count(w, b);
      return addr;
   endfunction

   function automatic bit slot_frozen(logic [2:0] s);
      return slot_fault[s] || ((slot_words[s][31:0] & match_mask_r) != 0);
   endfunction

   function automatic rsp_item_type slot_report(logic [2:0] s);
      rsp_item_type r;
      logic [31:0]  lo;
      lo             = slot_words[s][31:0];
      r.matched      = (lo & match_mask_r) != 0;
      r.node_index   = lo & idx_mask_r;
      r.out_of_range = slot_fault[s];
      r.current_word = slot_words[s];
      return r;
   endfunction

   function automatic void step_trie(req_item_type it);
      rsp_item_type r;
      logic [31:0]  a;
      r = '0;
      case (it.cmd)
         CMD_LOAD: begin
            trie_table[it.table_addr]  = it.word;
            trie_loaded[it.table_addr] = 1'b1;
         end
         CMD_START: begin
            slot_words[it.slot] = it.word;
            slot_fault[it.slot] = 1'b0;
            r = slot_report(it.slot);
         end
         CMD_BYTE: begin
            if (!slot_frozen(it.slot)) begin
               a = walk_addr(slot_words[it.slot], it.data_byte);
               if (a < TABLE_ENTRIES) slot_words[it.slot] = trie_table[a[11:0]];
               else slot_fault[it.slot] = 1'b1;
            end
            r = slot_report(it.slot);
         end
         default: ;
      endcase
      slot_report_q.push_back(r);
   endfunction

   function automatic logic [63:0] trie_node();
      logic [31:0] idx;
      logic [31:0] lo;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      idx  = (pick == 9) ? $urandom : $urandom_range(0, 3800);
      lo   = idx & idx_mask_r;
      if (pick >= 4 && pick <= 6) lo = lo | (rng_type_r & ~idx_mask_r);
      else if (pick == 7) lo = lo | ($urandom & ~idx_mask_r);
      else if (pick == 8) lo = lo | match_mask_r;
      else if (pick == 9) lo = $urandom;
      return {$urandom, lo};
   endfunction

   task automatic send_item(req_item_type it);
      if (!quiet_run && $urandom_range(0, 99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      step_trie(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic load_entry(logic [11:0] addr, logic [63:0] w);
      req_item_type it;
      it.cmd        = CMD_LOAD;
      it.slot       = 3'($urandom);
      it.table_addr = addr;
      it.word       = w;
      it.data_byte  = 8'($urandom);
      send_item(it);
   endtask

   task automatic start_slot(int unsigned s, logic [63:0] w);
      req_item_type it;
      it.cmd        = CMD_START;
      it.slot       = 3'(s);
      it.table_addr = 12'($urandom);
      it.word       = w;
      it.data_byte  = 8'($urandom);
      send_item(it);
   endtask

   // load the entry that the walk will fetch if it was never written
   task automatic feed_byte(int unsigned s, logic [7:0] b);
      req_item_type it;
      logic [31:0]  a;
      logic [2:0]   si;
      si = 3'(s);
      if (!slot_frozen(si)) begin
         a = walk_addr(slot_words[si], b);
         if (a < TABLE_ENTRIES && !trie_loaded[a[11:0]]) load_entry(a[11:0], trie_node());
      end
      it.cmd        = CMD_BYTE;
      it.slot       = si;
      it.table_addr = 12'($urandom);
      it.word       = {$urandom, $urandom};
      it.data_byte  = b;
      send_item(it);
   endtask

   task automatic send_unused(req_item_type it);
      it.cmd = CMD_NONE;
      send_item(it);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (slot_report_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INDEX_MASK: idx_mask_r   = val;
         CSR_RANGE_TYPE: rng_type_r   = val;
         CSR_MATCH_MASK: match_mask_r = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(logic [31:0] im, logic [31:0] rt, logic [31:0] mm,
                            bit poke_unused);
      drain();
      if (poke_unused) write_reg(CSR_UNUSED, $urandom);
      write_reg(CSR_INDEX_MASK, im);
      write_reg(CSR_RANGE_TYPE, rt);
      write_reg(CSR_MATCH_MASK, mm);
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_walks();
      configure(INDEX_MASK_RST, RANGE_TYPE_RST, MATCH_MASK_RST, 1'b1);
      send_unused('1);
      load_entry(12'd0, 64'd0);
      load_entry(12'hFFF, '1);
      feed_byte(0, 8'h00);
      feed_byte(0, 8'hFF);
      start_slot(1, 64'h7F00_FF80_4000_0100);
      feed_byte(1, 8'h80);
      start_slot(1, 64'h7F00_FF80_4000_0100);
      feed_byte(1, 8'h7F);
      start_slot(2, 64'h0000_0000_8000_0005);
      feed_byte(2, 8'h12);
      start_slot(3, 64'h0000_0000_0000_0FFF);
      feed_byte(3, 8'h01);
      feed_byte(3, 8'h00);
      start_slot(3, 64'h0000_0000_0000_0FFF);
      feed_byte(3, 8'h00);
      start_slot(7, '1);
      feed_byte(7, 8'h55);
   endtask

   // all index bits, range type zero: type-zero nodes take both offsets
   task automatic test_wide_index();
      configure('1, 32'd0, 32'd0, 1'b0);
      start_slot(4, 64'h8080_8080_FFFF_FFFF);
      feed_byte(4, 8'h01);
      feed_byte(5, 8'h7F);
   endtask

   task automatic test_type_extremes();
      configure(32'd0, '1, '1, 1'b0);
      start_slot(6, 64'd0);
      feed_byte(6, 8'h42);
      start_slot(6, 64'd1);
      feed_byte(6, 8'h42);
      configure(32'h0000_0FFF, 32'h0000_1000, 32'h8000_0000, 1'b0);
      start_slot(6, 64'h0000_0000_0000_2123);
      feed_byte(6, 8'hEE);
      start_slot(6, 64'h0102_0304_0000_1010);
      feed_byte(6, 8'h03);
   endtask

   task automatic test_random_traffic(int unsigned n);
      int unsigned first;
      int unsigned s;
      int unsigned r;
      first = items_sent;
      while (items_sent - first < n) begin
         r = $urandom_range(0, 99);
         s = $urandom_range(0, SLOTS - 1);
         if (r < 75) begin
            if ($urandom_range(0, 2) != 0) start_slot(s, trie_node());
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 4) == 0) feed_byte($urandom_range(0, SLOTS - 1),
                                                        8'($urandom));
               else feed_byte(s, 8'($urandom));
            end
         end else if (r < 85) begin
            load_entry(12'($urandom), {$urandom, $urandom});
         end else if (r < 92) begin
            start_slot(s, {$urandom, $urandom});
         end else begin
            send_unused(req_item_type'({$urandom, $urandom, $urandom}));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (slot_report_q.size() == 0) begin
            $error("result with none pending: %p", rsp_item);
            fail_count++;
         end else begin
            want = slot_report_q.pop_front();
            if (rsp_item.matched !== want.matched) begin
               $error("matched: expected %0h, actual %0h", want.matched, rsp_item.matched);
               fail_count++;
            end
            if (rsp_item.node_index !== want.node_index) begin
               $error("node_index: expected %h, actual %h", want.node_index,
                      rsp_item.node_index);
               fail_count++;
            end
            if (rsp_item.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0h, actual %0h", want.out_of_range,
                      rsp_item.out_of_range);
               fail_count++;
            end
            if (rsp_item.current_word !== want.current_word) begin
               $error("current_word: expected %h, actual %h", want.current_word,
                      rsp_item.current_word);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_INDEX_MASK;
      csr_data  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_default_walks();
      test_wide_index();
      test_type_extremes();
      configure(INDEX_MASK_RST, RANGE_TYPE_RST, MATCH_MASK_RST, 1'b0);
      test_random_traffic(300);
      configure(32'h0000_0FFF, 32'h0000_1000, 32'h8000_0000, 1'b0);
      test_random_traffic(300);
      quiet_run = 1'b1;
      configure('1, 32'd0, 32'd0, 1'b0);
      test_random_traffic(300);
      quiet_run = 1'b0;
      configure(32'h00FF_FFFF, 32'h5A00_0000, 32'h0000_0001, 1'b0);
      test_random_traffic(300);
      drain();
      repeat (6) @(negedge clock);
      if (fail_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
